>>> hdl/ida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ida_pkg: shared types and constants of the lowest-free ID allocator
// Holds the ID space size, derived widths, operation and status codes, and the
// structs for one item, one result and one bitmap search between modules.
// ----------------------------------------------------------------------------
package ida_pkg;

  localparam int unsigned ID_COUNT = 256;
  localparam int unsigned ID_W     = $clog2(ID_COUNT);
  // The high-water mark must be able to hold ID_COUNT itself.
  localparam int unsigned HW_W     = $clog2(ID_COUNT + 1);

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_RELEASED  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef struct packed {
    logic             valid;
    func_e            func;
    logic [ID_W-1:0]  release_id;
  } ida_item_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  granted_id;
    status_e          status;
  } ida_result_t;

  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  index;
  } ida_search_t;

endpackage : ida_pkg
`default_nettype wire

>>> hdl/ida_prio_enc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ida_prio_enc: lowest set bit finder
// Reports whether any freed bit is set and the index of the lowest one.
// ----------------------------------------------------------------------------
module ida_prio_enc
  import ida_pkg::*;
(
  input  logic [ID_COUNT-1:0] map_i,
  output ida_search_t         search_o
);

  always_comb begin
    search_o = '0;
    // Scan from the top so the lowest set bit wins.
    for (int i = ID_COUNT - 1; i >= 0; i--) begin
      if (map_i[i]) begin
        search_o.found = 1'b1;
        search_o.index = ID_W'(i);
      end
    end
  end

endmodule : ida_prio_enc
`default_nettype wire

>>> hdl/ida_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ida_exec: allocator state and execute stage
// Holds the high-water mark and freed bitmap, executes one registered item per
// cycle and registers its result.
// ----------------------------------------------------------------------------
module ida_exec
  import ida_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ida_item_t   item_i,
  output ida_result_t result_o
);

  logic [HW_W-1:0]     hw_q, hw_d;
  logic [ID_COUNT-1:0] freed_q, freed_d;
  ida_result_t         result_q, result_d;
  ida_search_t         search;
  logic [HW_W-1:0]     rid_ext;

  ida_prio_enc u_prio_enc (
    .map_i    (freed_q),
    .search_o (search)
  );

  assign rid_ext = HW_W'(item_i.release_id);

  always_comb begin
    hw_d                = hw_q;
    freed_d             = freed_q;
    result_d            = '0;
    result_d.valid      = item_i.valid;
    result_d.status     = ST_GRANTED;
    if (item_i.valid) begin
      case (item_i.func)
        FUNC_ALLOC: begin
          if (search.found) begin
            // Reuse the lowest freed ID.
            freed_d[search.index] = 1'b0;
            result_d.granted_id   = search.index;
          end else if (hw_q != HW_W'(ID_COUNT)) begin
            result_d.granted_id = hw_q[ID_W-1:0];
            hw_d                = hw_q + 1'b1;
          end else begin
            result_d.status = ST_EXHAUSTED;
          end
        end
        FUNC_RELEASE: begin
          if (rid_ext >= hw_q) begin
            result_d.status = ST_IGNORED;
          end else if (rid_ext == hw_q - 1'b1) begin
            // Topmost issued ID: drop the mark, keep no bit above it.
            hw_d                         = hw_q - 1'b1;
            freed_d[item_i.release_id]   = 1'b0;
            result_d.status              = ST_RELEASED;
          end else begin
            freed_d[item_i.release_id] = 1'b1;
            result_d.status            = ST_RELEASED;
          end
        end
        default: begin
          result_d.status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q     <= '0;
      freed_q  <= '0;
      result_q <= '0;
    end else begin
      hw_q     <= hw_d;
      freed_q  <= freed_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

`ifndef SYNTH
  a_hw_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= HW_W'(ID_COUNT))
    else $error("high-water mark beyond ID space");

  a_no_bit_above_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (freed_q >> hw_q) == '0)
    else $error("freed bit set at or above the mark");

  a_fresh_grant_raises : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.func == FUNC_ALLOC && !search.found &&
     hw_q != HW_W'(ID_COUNT)) |=> (hw_q == $past(hw_q) + 1'b1))
    else $error("fresh grant did not raise the mark");

  a_reuse_clears_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.func == FUNC_ALLOC && search.found)
      |=> (result_q.granted_id == $past(search.index) && $stable(hw_q)))
    else $error("reused ID not granted or mark moved");

  a_zero_unless_granted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_q.valid && result_q.status != ST_GRANTED) |-> (result_q.granted_id == '0))
    else $error("nonzero ID on a result that grants nothing");
`endif

endmodule : ida_exec
`default_nettype wire

>>> hdl/id_allocator_lowest_free_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id_allocator_lowest_free_top: lowest-free numeric ID allocator
// Hands out IDs 0..255, reusing the lowest freed ID first, and takes them back.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                  | Handshake
//  ---------+----------------------------------------+---------------------------
//  request  | func_i, release_id_i                   | start_i && !busy_o
//  result   | granted_id_o, status_o                 | done_o, one-cycle strobe
//
// An item taken at one edge is registered, executed against the mark and the
// freed bitmap in the next cycle, and its result is registered again before it
// shows on done_o; one item per cycle is sustained while busy_o is low.
// The throughput is set by the combinational search for the lowest freed bit.
// Reset clears the mark and all freed bits at once; busy_o stays high for the
// first cycle after reset and low from then on.
// The receiver cannot stall: every result is presented for exactly one cycle.
//
module id_allocator_lowest_free_top
  import ida_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            func_i,
  input  logic [ID_W-1:0] release_id_i,
  output logic            done_o,
  output logic [ID_W-1:0] granted_id_o,
  output logic [1:0]      status_o
);

  logic        busy_q;
  ida_item_t   item_q, item_d;
  ida_result_t result;

  // Hold off requests for one cycle after reset release.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  // Capture the item; the execute stage consumes it in the next cycle.
  always_comb begin
    item_d.valid      = start_i && !busy_q;
    item_d.func       = func_e'(func_i);
    item_d.release_id = release_id_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  // Execute against the allocator state and register the result.
  ida_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_q),
    .result_o (result)
  );

  assign done_o       = result.valid;
  assign granted_id_o = result.granted_id;
  assign status_o     = result.status;

`ifndef SYNTH
  a_one_result_per_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted item produced no result");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(start_i && !busy_o)) |-> ##2 !done_o)
    else $error("result without an accepted item");

  a_busy_only_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy raised outside reset");
`endif

endmodule : id_allocator_lowest_free_top
`default_nettype wire
